FILE: design/packed_six_bit_string_encoder_assert.svh
// Assertion macros for the packed six-bit string encoder.
`ifndef PACKED_SIX_BIT_STRING_ENCODER_ASSERT_SVH
`define PACKED_SIX_BIT_STRING_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define PSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pse_pkg.sv
// Shared types, constants and the symbol table of the six-bit string encoder.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  // Default longest string
  localparam int MAX_LEN_DEF = 63;
  // Length field width, covers the whole legal range of the length limit
  localparam int CNT_W = 7;

  // Input operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_END    = 1'b1;

  // Header flag of a packed body
  localparam logic HDR_PACKED = 1'b1;
  localparam logic HDR_RAW    = 1'b0;

  // One finished string, handed from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] cnt;
    logic             enc;
    logic             ovf;
  } job_t;

  // Symbol lookup: bit 6 set when the byte is in the alphabet, bits 5:0 the code
  function automatic logic [6:0] code_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h61;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h11;
    end else if (c >= 8'h41 && c <= 8'h48) begin
      d = c - 8'h18;
    end else if (c >= 8'h4a && c <= 8'h4e) begin
      d = c - 8'h19;
    end else if (c == 8'h50 || c == 8'h51) begin
      d = c - 8'h1a;
    end else if (c >= 8'h53 && c <= 8'h58) begin
      d = c - 8'h1b;
    end else if (c == 8'h5a) begin
      d = 8'd62;
    end else if (c == 8'h23) begin
      d = 8'd26;
    end else if (c == 8'h2f) begin
      d = 8'd27;
    end else if (c == 8'h2d) begin
      d = 8'd28;
    end else if (c == 8'h5f) begin
      d = 8'd29;
    end else if (c == 8'h20) begin
      d = 8'd30;
    end else if (c == 8'h2e) begin
      d = 8'd63;
    end else begin
      d = 8'hff;
    end
    code_of = {(d != 8'hff), d[5:0]};
  endfunction

endpackage
`default_nettype wire

FILE: design/pse_front.sv
// Front end: takes append and end transactions, writes the text store, classifies strings.
`timescale 1ns / 1ps
`default_nettype none
module pse_front #(
  parameter int MAX_LEN = pse_pkg::MAX_LEN_DEF,
  parameter int AW      = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [7:0]        in_char_code,
  input  wire logic              q_full,
  output logic                   q_push,
  output pse_pkg::job_t          q_job,
  output logic                   wr_en,
  output logic [AW:0]            wr_addr,
  output logic [7:0]             wr_data
);

  localparam logic [pse_pkg::CNT_W-1:0] LIMIT = pse_pkg::CNT_W'(MAX_LEN);

  logic                        bank_r, bank_nxt;
  logic [pse_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        enc_r, enc_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        acc;
  logic [6:0]                  sym;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign sym      = pse_pkg::code_of(in_char_code);

  // Store write and job hand-off
  assign wr_en   = acc && (in_opcode == pse_pkg::OP_APPEND) && (cnt_r < LIMIT);
  assign wr_addr = {bank_r, cnt_r[AW-1:0]};
  assign wr_data = in_char_code;
  assign q_push  = acc && (in_opcode == pse_pkg::OP_END);
  assign q_job   = '{bank: bank_r, cnt: cnt_r, enc: enc_r, ovf: ovf_r};

  // String bookkeeping
  always_comb begin
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    enc_nxt  = enc_r;
    ovf_nxt  = ovf_r;
    if (acc) begin
      if (in_opcode == pse_pkg::OP_END) begin
        bank_nxt = !bank_r;
        cnt_nxt  = '0;
        enc_nxt  = 1'b1;
        ovf_nxt  = 1'b0;
      end else if (cnt_r >= LIMIT) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        enc_nxt = enc_r && sym[6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      enc_r  <= 1'b1;
      ovf_r  <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      enc_r  <= enc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/pse_queue.sv
// Two-entry job queue between front and back; one entry per text store bank.
`timescale 1ns / 1ps
`default_nettype none
module pse_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pse_pkg::job_t push_job,
  input  wire logic          pop,
  output pse_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  pse_pkg::job_t slot_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign head  = slot_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  // Pointer and fill update
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

FILE: design/pse_back.sv
// Back end: text store and the sequencer that emits header, packed or raw body bytes.
`timescale 1ns / 1ps
`default_nettype none
module pse_back #(
  parameter int AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW:0]       wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire pse_pkg::job_t     job,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte,
  output logic                   out_too_long
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_HDR   = 3'd1;
  localparam logic [2:0] B_RD    = 3'd2;
  localparam logic [2:0] B_CH    = 3'd3;
  localparam logic [2:0] B_FLUSH = 3'd4;

  logic [7:0]    mem [2**(AW+1)];
  logic [7:0]    rd_data_r;
  logic          rd_en;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          ot_r, ot_nxt;

  logic          slot_free;
  logic [6:0]    rd_sym;
  logic [5:0]    code;
  logic [15:0]   merged;
  logic [3:0]    pos_sum;
  logic          last_char;
  logic [2:0]    pk_pos;

  // Text store: one write port from the front, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[{job.bank, idx_r}];
    end
  end

  assign slot_free = !ov_r || out_ready;

  // Packing of one six-bit code at the current bit position
  assign rd_sym    = pse_pkg::code_of(rd_data_r);
  assign code      = rd_sym[5:0];
  assign merged    = {acc_r, 8'h00} | ({code, 10'b0} >> pos_r);
  assign pos_sum   = {1'b0, pos_r} + 4'd6;
  assign pk_pos    = pos_sum[2:0];
  assign last_char = (pse_pkg::CNT_W'(idx_r) == job.cnt - 1'b1);

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    ov_nxt  = ov_r && !out_ready;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    ot_nxt  = ot_r;
    rd_en   = 1'b0;
    q_pop   = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          st_nxt = B_HDR;
        end
      end
      B_HDR: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          idx_nxt = '0;
          acc_nxt = 8'h00;
          pos_nxt = 3'd0;
          if (job.ovf) begin
            ob_nxt = 8'h00;
            ol_nxt = 1'b1;
            ot_nxt = 1'b1;
            q_pop  = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            ob_nxt = {job.enc ? pse_pkg::HDR_PACKED : pse_pkg::HDR_RAW, job.cnt};
            ot_nxt = 1'b0;
            ol_nxt = (job.cnt == '0);
            if (job.cnt == '0) begin
              q_pop  = 1'b1;
              st_nxt = B_IDLE;
            end else begin
              st_nxt = B_RD;
            end
          end
        end
      end
      B_RD: begin
        rd_en  = 1'b1;
        st_nxt = B_CH;
      end
      B_CH: begin
        if (job.enc) begin
          if (!pos_sum[3] || slot_free) begin
            acc_nxt = pos_sum[3] ? merged[7:0] : merged[15:8];
            pos_nxt = pk_pos;
            if (pos_sum[3]) begin
              ov_nxt = 1'b1;
              ob_nxt = merged[15:8];
              ot_nxt = 1'b0;
              ol_nxt = last_char && (pk_pos == 3'd0);
            end
            idx_nxt = idx_r + 1'b1;
            if (!last_char) begin
              st_nxt = B_RD;
            end else if (pk_pos != 3'd0) begin
              st_nxt = B_FLUSH;
            end else begin
              q_pop  = 1'b1;
              st_nxt = B_IDLE;
            end
          end
        end else if (slot_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = rd_data_r;
          ot_nxt  = 1'b0;
          ol_nxt  = last_char;
          idx_nxt = idx_r + 1'b1;
          if (last_char) begin
            q_pop  = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            st_nxt = B_RD;
          end
        end
      end
      B_FLUSH: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ob_nxt = acc_r;
          ot_nxt = 1'b0;
          ol_nxt = 1'b1;
          q_pop  = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Packing and output payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    pos_r <= pos_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    ot_r  <= ot_nxt;
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_last_byte = ol_r;
  assign out_too_long  = ot_r;

endmodule
`default_nettype wire

FILE: design/packed_six_bit_string_encoder.sv
// Top level of the packed six-bit string encoder.
// Usage:
//   Input channel (in_valid/in_ready): in_opcode 0 appends in_char_code to the
//   current string, 1 ends it. Appends are taken one per cycle while in_ready
//   is high; a character beyond MAX_LEN is dropped and the string is marked too long.
//   Result channel (out_valid/out_ready): one byte per transaction. A string
//   gives a header (length, bit 7 set when packed) then its body, or a single
//   zero byte with out_too_long set. out_last_byte marks the final byte.
//   The header is registered in the output once the back end is free and the
//   job is at the queue head. The body drains through the single read port of
//   the text store: each stored character is read in B_RD and then sent or
//   packed in B_CH, and a final padded byte, if any, is sent from B_FLUSH.
//   Two strings can be held at once (two store banks and a two-entry queue);
//   while both are held, in_ready is low.
//   When the receiver stalls, the output register holds its byte and the
//   back end waits; the front keeps loading the next string meanwhile.
//   Reset clears all control state; the text store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_six_bit_string_encoder_assert.svh"
module packed_six_bit_string_encoder #(
  parameter int MAX_LEN = pse_pkg::MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_opcode,
  input  wire logic [7:0] in_char_code,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_byte,
  output logic            out_too_long
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  pse_pkg::job_t q_job;
  pse_pkg::job_t q_head;
  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [7:0]    wr_data;

  // Front end
  pse_front #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Job queue
  pse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end
  pse_back #(
    .AW (AW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .job           (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_too_long  (out_too_long)
  );

  // Checks
  `PSE_ASSERT_NOW(a_err_alone, clk, rst_n, out_valid && out_too_long, out_last_byte && out_byte == 8'h00, "error transaction is not a lone zero final byte")
  `PSE_ASSERT_NOW(a_push_room, clk, rst_n, q_push, !q_full, "job pushed into a full queue")
  `PSE_ASSERT_NOW(a_pop_data, clk, rst_n, q_pop, !q_empty, "job popped from an empty queue")
  `PSE_ASSERT_NEXT(a_push_seen, clk, rst_n, q_push && !q_pop, !q_empty, "pushed job lost from the queue")

endmodule
`default_nettype wire
